[rtl/core/ring_deque_defines.svh]
// ----------------------------------------------------------------------------
// ring_deque_defines.svh
// Assertion macros of the ring deque checker.
// ----------------------------------------------------------------------------
`ifndef RING_DEQUE_DEFINES_SVH
`define RING_DEQUE_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define RDQ_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define RDQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/rdq_pkg.sv]
// ----------------------------------------------------------------------------
// rdq_pkg
// Types, codes and default sizes of the ring deque.
// ----------------------------------------------------------------------------
package rdq_pkg;

  // Default sizes
  localparam int CAPACITY_DEF    = 64;
  localparam int VALUE_WIDTH_DEF = 32;

  // Fixed field widths of the request and result items
  localparam int ENTRY_W = 32;
  localparam int OCC_W   = 7;

  // Operation codes
  typedef enum logic [1:0] {
    OP_PUSH_BACK  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_QUERY      = 2'd3
  } opcode_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic exec;   // apply the accepted request to pointers and slots
    logic rd;     // read both ends and latch the flags
    logic load;   // load the result register
  } rdq_cmd_t;

endpackage

[rtl/core/rdq_if.sv]
// ----------------------------------------------------------------------------
// rdq_if
// Request and result channels of the ring deque (valid/ready).
// ----------------------------------------------------------------------------
interface rdq_req_if;
  import rdq_pkg::*;

  logic                 valid;
  logic                 ready;
  opcode_t              opcode;
  logic [ENTRY_W-1:0]   entry_value;

  modport source (output valid, output opcode, output entry_value, input ready);
  modport sink   (input valid, input opcode, input entry_value, output ready);
endinterface

interface rdq_rsp_if;
  import rdq_pkg::*;

  logic                 valid;
  logic                 ready;
  status_t              status;
  logic [OCC_W-1:0]     occupancy;
  logic                 is_empty;
  logic                 is_full;
  logic [ENTRY_W-1:0]   head_value;
  logic [ENTRY_W-1:0]   tail_value;

  modport source (output valid, output status, output occupancy, output is_empty,
                  output is_full, output head_value, output tail_value, input ready);
  modport sink   (input valid, input status, input occupancy, input is_empty,
                  input is_full, input head_value, input tail_value, output ready);
endinterface

[rtl/core/rdq_ram.sv]
// ----------------------------------------------------------------------------
// rdq_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module rdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read two words into the output registers
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

[rtl/core/rdq_ctrl.sv]
// ----------------------------------------------------------------------------
// rdq_ctrl
// Sequencer of the ring deque: request handshake, steps, result valid.
// ----------------------------------------------------------------------------
module rdq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output rdq_pkg::rdq_cmd_t cmd
);
  import rdq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_LOAD = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  // Decode commands
  always_comb begin
    out_free  = !rsp_valid || rsp_ready;
    req_ready = (state == S_IDLE);
    cmd.exec  = req_valid && (state == S_IDLE);
    cmd.rd    = (state == S_READ);
    cmd.load  = (state == S_LOAD) && out_free;
  end

  // Advance through apply, read and load
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_READ;
      end
      S_READ: begin
        state_next = S_LOAD;
      end
      S_LOAD: begin
        if (out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold result valid until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule

[rtl/core/rdq_dpath.sv]
// ----------------------------------------------------------------------------
// rdq_dpath
// Pointers, slot memory and result register of the ring deque.
// ----------------------------------------------------------------------------
module rdq_dpath #(
  parameter int CAPACITY    = rdq_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = rdq_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rdq_pkg::rdq_cmd_t             cmd,
  input  rdq_pkg::opcode_t              opcode,
  input  logic [rdq_pkg::ENTRY_W-1:0]   entry_value,
  output rdq_pkg::status_t              status,
  output logic [rdq_pkg::OCC_W-1:0]     occupancy,
  output logic                          is_empty,
  output logic                          is_full,
  output logic [rdq_pkg::ENTRY_W-1:0]   head_value,
  output logic [rdq_pkg::ENTRY_W-1:0]   tail_value
);
  import rdq_pkg::*;

  localparam int NSLOTS = CAPACITY + 1;
  localparam int PTR_W  = $clog2(NSLOTS);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(CAPACITY);
  localparam logic [PTR_W:0]   SLOTS_W   = (PTR_W+1)'(NSLOTS);

  logic [PTR_W-1:0]       head_ptr;
  logic [PTR_W-1:0]       tail_ptr;
  logic [PTR_W-1:0]       head_ptr_next;
  logic [PTR_W-1:0]       tail_ptr_next;
  logic [PTR_W-1:0]       head_inc;
  logic [PTR_W-1:0]       head_dec;
  logic [PTR_W-1:0]       tail_inc;
  logic                   now_empty;
  logic                   now_full;
  logic [PTR_W:0]         occ_wide;
  status_t                status_d;
  status_t                status_q;
  logic [PTR_W-1:0]       occ_q;
  logic                   empty_q;
  logic                   full_q;
  logic                   we;
  logic [PTR_W-1:0]       waddr;
  logic [VALUE_WIDTH-1:0] wdata;
  logic [VALUE_WIDTH-1:0] rd_head;
  logic [VALUE_WIDTH-1:0] rd_tail;

  // Neighbor slots and flags of the current pointers
  always_comb begin
    head_inc  = (head_ptr == LAST_SLOT) ? '0 : head_ptr + PTR_W'(1);
    head_dec  = (head_ptr == '0) ? LAST_SLOT : head_ptr - PTR_W'(1);
    tail_inc  = (tail_ptr == LAST_SLOT) ? '0 : tail_ptr + PTR_W'(1);
    now_empty = (head_ptr == tail_ptr);
    now_full  = (tail_inc == head_ptr);
    if (tail_ptr >= head_ptr) begin
      occ_wide = {1'b0, tail_ptr} - {1'b0, head_ptr};
    end else begin
      occ_wide = {1'b0, tail_ptr} + SLOTS_W - {1'b0, head_ptr};
    end
  end

  // Apply the request: pick the slot write and the pointer moves
  always_comb begin
    head_ptr_next = head_ptr;
    tail_ptr_next = tail_ptr;
    status_d      = ST_DONE;
    we            = 1'b0;
    waddr         = tail_inc;
    wdata         = VALUE_WIDTH'(entry_value);
    unique case (opcode)
      OP_PUSH_BACK: begin
        if (now_full) begin
          status_d = ST_FULL;
        end else begin
          tail_ptr_next = tail_inc;
          we            = cmd.exec;
          waddr         = tail_inc;
        end
      end
      OP_PUSH_FRONT: begin
        if (now_full) begin
          status_d = ST_FULL;
        end else begin
          head_ptr_next = head_dec;
          we            = cmd.exec;
          waddr         = head_ptr;
        end
      end
      OP_POP_FRONT: begin
        if (now_empty) begin
          status_d = ST_EMPTY;
        end else begin
          // clear the slot that becomes the free one
          head_ptr_next = head_inc;
          we            = cmd.exec;
          waddr         = head_inc;
          wdata         = '0;
        end
      end
      OP_QUERY: begin
        status_d = ST_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_ptr <= '0;
      tail_ptr <= '0;
    end else if (cmd.exec) begin
      head_ptr <= head_ptr_next;
      tail_ptr <= tail_ptr_next;
    end
  end

  // Latch status at apply, flags at read
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_q <= status_d;
    end
    if (cmd.rd) begin
      occ_q   <= occ_wide[PTR_W-1:0];
      empty_q <= now_empty;
      full_q  <= now_full;
    end
  end

  rdq_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (NSLOTS)
  ) u_slots (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .re      (cmd.rd),
    .raddr_a (head_inc),
    .raddr_b (tail_ptr),
    .rdata_a (rd_head),
    .rdata_b (rd_tail)
  );

  // Load the result register; an empty queue shows zero at both ends
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status     <= status_q;
      occupancy  <= OCC_W'(occ_q);
      is_empty   <= empty_q;
      is_full    <= full_q;
      head_value <= empty_q ? '0 : ENTRY_W'(rd_head);
      tail_value <= empty_q ? '0 : ENTRY_W'(rd_tail);
    end
  end

endmodule

[rtl/core/ring_deque.sv]
// ----------------------------------------------------------------------------
// ring_deque
// Double-ended ring queue: push back, push front, pop front and query.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  req      in   opcode, entry_value
//  rsp      out  status, occupancy, is_empty, is_full, head_value, tail_value
//
//  A request goes from accept to result valid through apply (pointer move
//  and slot write), read of both ends through the registered memory ports,
//  load of the result register. One request is in work at a time.
//  A new request is accepted while a result waits in the output register;
//  its result then holds until the sink takes the waiting one.
//  Reset clears pointers and valid bits; slots are not cleared.
// ----------------------------------------------------------------------------
module ring_deque #(
  parameter int CAPACITY    = rdq_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = rdq_pkg::VALUE_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  rdq_req_if.sink  req,
  rdq_rsp_if.source rsp
);
  import rdq_pkg::*;

  rdq_cmd_t cmd;

  rdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  rdq_dpath #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .opcode      (req.opcode),
    .entry_value (req.entry_value),
    .status      (rsp.status),
    .occupancy   (rsp.occupancy),
    .is_empty    (rsp.is_empty),
    .is_full     (rsp.is_full),
    .head_value  (rsp.head_value),
    .tail_value  (rsp.tail_value)
  );

endmodule

[rtl/core/rdq_checker.sv]
// ----------------------------------------------------------------------------
// rdq_checker
// Port-level checks of the ring deque, bound to the top level.
// ----------------------------------------------------------------------------
`include "ring_deque_defines.svh"

module rdq_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_ready,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input rdq_pkg::status_t            status,
  input logic [rdq_pkg::OCC_W-1:0]   occupancy,
  input logic                        is_empty,
  input logic [rdq_pkg::ENTRY_W-1:0] head_value,
  input logic [rdq_pkg::ENTRY_W-1:0] tail_value
);
  import rdq_pkg::*;

  // A stalled result stays valid
  `RDQ_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid, "result dropped")

  // One request at a time: the port closes after an accept
  `RDQ_ASSERT_NEXT(a_one_in_work, clk, rst, req_valid && req_ready, !req_ready, "second request taken")

  // An empty queue reports no entries and zero ends
  `RDQ_ASSERT_SAME(a_empty_zero, clk, rst, rsp_valid && is_empty,
    occupancy == '0 && head_value == '0 && tail_value == '0, "empty result not zero")

  // A refusal for lack of entries comes only from an empty queue
  `RDQ_ASSERT_SAME(a_refuse_empty, clk, rst, rsp_valid && status == ST_EMPTY,
    is_empty, "pop refused on a queue with entries")

endmodule

bind ring_deque rdq_checker u_rdq_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .status     (rsp.status),
  .occupancy  (rsp.occupancy),
  .is_empty   (rsp.is_empty),
  .head_value (rsp.head_value),
  .tail_value (rsp.tail_value)
);
